FILE: hw/rtl/mring_pkg.sv
// shared constants, types and helpers for the message ring
package mring_pkg;

  localparam int unsigned Slots        = 8;
  localparam int unsigned BytesPerSlot = 64;

  localparam int unsigned SlotW = $clog2(Slots);
  localparam int unsigned IdxW  = (BytesPerSlot > 1) ? $clog2(BytesPerSlot) : 1;
  localparam int unsigned LenW  = $clog2(BytesPerSlot + 1);
  localparam int unsigned HeldW = $clog2(Slots + 1);
  localparam int unsigned AddrW = $clog2(Slots * BytesPerSlot);
  localparam int unsigned ByteW = 8;

  localparam logic KindWrite = 1'b0;
  localparam logic KindDrain = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StLen,
    StOut
  } drain_state_e;

  typedef logic [SlotW-1:0] slot_t;
  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [LenW-1:0]  len_t;
  typedef logic [HeldW-1:0] held_t;
  typedef logic [AddrW-1:0] addr_t;

  function automatic addr_t slot_addr(slot_t slot, idx_t idx);
    int unsigned full;
    full = int'(slot) * BytesPerSlot + int'(idx);
    return full[AddrW-1:0];
  endfunction

  function automatic slot_t next_slot(slot_t slot);
    slot_t res;
    if (slot == SlotW'(Slots - 1)) begin
      res = '0;
    end else begin
      res = slot + SlotW'(1);
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/mring_ram.sv
// generic single write port, single read port ram with registered read data
module mring_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  parameter int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/message_ring_overwrite_oldest_core.sv
// message ring top level: write assembly, overwrite of oldest, drain sequencer
// A write request (kind 0) stores one message byte, or drops it if the slot is
// full, so bytes can be taken on every clock while busy is low; the byte
// marked end of message commits it, and a new message arriving while all slots
// hold messages discards the oldest. A drain request (kind 1) on an empty ring
// finishes in its accept cycle with no output. Otherwise busy is high in StLen
// and StOut: the accept edge reads the length and the first byte together, StLen
// loads the length, then in StOut one byte per cycle is shown for a single cycle
// with strobe_o, last_of_run_o on the final byte. The receiver cannot stall;
// every strobed byte must be taken when it appears.
module message_ring_overwrite_oldest_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       kind_i,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_message_i,
  output logic       strobe_o,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);

  mring_pkg::drain_state_e state_q, state_d;
  mring_pkg::slot_t wr_slot_q, wr_slot_d;
  mring_pkg::slot_t rd_slot_q, rd_slot_d;
  mring_pkg::held_t held_q, held_d;
  mring_pkg::len_t  fill_q, fill_d;
  mring_pkg::len_t  len_q, len_d;
  mring_pkg::idx_t  cnt_q, cnt_d;

  logic                 byte_we;
  mring_pkg::addr_t     byte_waddr;
  mring_pkg::addr_t     byte_raddr;
  logic [7:0]           byte_rdata;
  logic                 len_we;
  mring_pkg::len_t      len_wdata;
  mring_pkg::len_t      len_rdata;

  logic                 accept;
  logic                 discard;
  logic                 room;
  mring_pkg::held_t     held_after;
  mring_pkg::len_t      fill_inc;
  logic                 is_last;

  mring_ram #(
    .Width (mring_pkg::ByteW),
    .Depth (mring_pkg::Slots * mring_pkg::BytesPerSlot),
    .AW    (mring_pkg::AddrW)
  ) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (byte_we),
    .waddr_i (byte_waddr),
    .wdata_i (in_byte_i),
    .raddr_i (byte_raddr),
    .rdata_o (byte_rdata)
  );

  mring_ram #(
    .Width (mring_pkg::LenW),
    .Depth (mring_pkg::Slots),
    .AW    (mring_pkg::SlotW)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (wr_slot_q),
    .wdata_i (len_wdata),
    .raddr_i (rd_slot_q),
    .rdata_o (len_rdata)
  );

  assign accept     = start && (state_q == mring_pkg::StIdle);
  assign discard    = (fill_q == '0) && (held_q == mring_pkg::HeldW'(mring_pkg::Slots));
  assign room       = fill_q < mring_pkg::LenW'(mring_pkg::BytesPerSlot);
  assign held_after = discard ? mring_pkg::HeldW'(mring_pkg::Slots - 1) : held_q;
  assign fill_inc   = room ? fill_q + mring_pkg::LenW'(1) : fill_q;
  assign is_last    = (mring_pkg::LenW'(cnt_q) + mring_pkg::LenW'(1)) == len_q;

  assign byte_waddr = mring_pkg::slot_addr(wr_slot_q, fill_q[mring_pkg::IdxW-1:0]);
  assign len_wdata  = fill_inc;

  always_comb begin
    state_d    = state_q;
    wr_slot_d  = wr_slot_q;
    rd_slot_d  = rd_slot_q;
    held_d     = held_q;
    fill_d     = fill_q;
    len_d      = len_q;
    cnt_d      = cnt_q;
    byte_we    = 1'b0;
    len_we     = 1'b0;
    byte_raddr = mring_pkg::slot_addr(rd_slot_q, '0);
    strobe_o   = 1'b0;
    last_of_run_o = 1'b0;
    unique case (state_q)
      mring_pkg::StIdle: begin
        if (accept && (kind_i == mring_pkg::KindWrite)) begin
          byte_we = room;
          if (discard) begin
            rd_slot_d = mring_pkg::next_slot(rd_slot_q);
          end
          if (end_of_message_i) begin
            len_we    = 1'b1;
            wr_slot_d = mring_pkg::next_slot(wr_slot_q);
            held_d    = held_after + mring_pkg::HeldW'(1);
            fill_d    = '0;
          end else begin
            held_d = held_after;
            fill_d = fill_inc;
          end
        end else if (accept && (held_q != '0)) begin
          state_d = mring_pkg::StLen;
        end
      end
      mring_pkg::StLen: begin
        len_d   = len_rdata;
        cnt_d   = '0;
        state_d = mring_pkg::StOut;
      end
      mring_pkg::StOut: begin
        strobe_o      = 1'b1;
        last_of_run_o = is_last;
        byte_raddr    = mring_pkg::slot_addr(rd_slot_q, cnt_q + mring_pkg::IdxW'(1));
        cnt_d         = cnt_q + mring_pkg::IdxW'(1);
        if (is_last) begin
          rd_slot_d = mring_pkg::next_slot(rd_slot_q);
          held_d    = held_q - mring_pkg::HeldW'(1);
          state_d   = mring_pkg::StIdle;
        end
      end
      default: begin
        state_d = mring_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mring_pkg::StIdle;
      wr_slot_q <= '0;
      rd_slot_q <= '0;
      held_q    <= '0;
      fill_q    <= '0;
    end else begin
      state_q   <= state_d;
      wr_slot_q <= wr_slot_d;
      rd_slot_q <= rd_slot_d;
      held_q    <= held_d;
      fill_q    <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    cnt_q <= cnt_d;
  end

  assign busy       = state_q != mring_pkg::StIdle;
  assign out_byte_o = byte_rdata;

endmodule

FILE: bench/message_ring_overwrite_oldest_core_tb.sv
// self-checking testbench for the message ring core with overwrite of the oldest message
`timescale 1ns / 100ps

module message_ring_overwrite_oldest_core_tb;

  localparam int unsigned RandomRequests = 480;
  localparam int unsigned SettleCycles   = mring_pkg::BytesPerSlot + 16;
  localparam int unsigned CycleLimit     = 200000;

  typedef struct {
    logic        kind;
    logic [7:0]  data;
    logic        eom;
    int unsigned gap;
  } ring_req_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } drain_byte_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       kind_i = mring_pkg::KindWrite;
  logic [7:0] in_byte_i = 8'h00;
  logic       end_of_message_i = 1'b0;
  logic       strobe_o;
  logic [7:0] out_byte_o;
  logic       last_of_run_o;

  message_ring_overwrite_oldest_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind_i),
    .in_byte_i       (in_byte_i),
    .end_of_message_i(end_of_message_i),
    .strobe_o        (strobe_o),
    .out_byte_o      (out_byte_o),
    .last_of_run_o   (last_of_run_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  ring_req_t   request_queue[$];
  drain_byte_t expected_drain_bytes[$];

  logic [7:0]       ring_mem [mring_pkg::Slots][mring_pkg::BytesPerSlot];
  mring_pkg::len_t  ring_len [mring_pkg::Slots];
  mring_pkg::slot_t ring_wr_slot = '0;
  mring_pkg::slot_t ring_rd_slot = '0;
  mring_pkg::held_t ring_held = '0;
  mring_pkg::len_t  ring_fill = '0;

  int unsigned n_writes = 0;
  int unsigned n_drains = 0;
  int unsigned n_empty_drains = 0;
  int unsigned n_overwrites = 0;
  int unsigned n_dropped_bytes = 0;
  int unsigned n_checked = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned pushed = 0;
  bit          no_idle = 1'b0;

  ring_req_t   cur_req;
  bit          have_req = 1'b0;
  int unsigned gap_left = 0;

  function automatic mring_pkg::slot_t ring_advance(mring_pkg::slot_t s);
    return mring_pkg::slot_t'((int'(s) + 1) % mring_pkg::Slots);
  endfunction

  task automatic apply_ring_request(input ring_req_t req);
    drain_byte_t db;
    if (req.kind == mring_pkg::KindWrite) begin
      n_writes++;
      if (ring_fill == 0 && ring_held == mring_pkg::held_t'(mring_pkg::Slots)) begin
        ring_rd_slot = ring_advance(ring_rd_slot);
        ring_held    = mring_pkg::held_t'(mring_pkg::Slots - 1);
        n_overwrites++;
      end
      if (ring_fill < mring_pkg::BytesPerSlot) begin
        ring_mem[ring_wr_slot][ring_fill] = req.data;
        ring_fill++;
      end else begin
        n_dropped_bytes++;
      end
      if (req.eom) begin
        ring_len[ring_wr_slot] = ring_fill;
        ring_wr_slot = ring_advance(ring_wr_slot);
        ring_held++;
        ring_fill = '0;
      end
    end else begin
      n_drains++;
      if (ring_held == 0) begin
        n_empty_drains++;
      end else begin
        for (int i = 0; i < int'(ring_len[ring_rd_slot]); i++) begin
          db.data = ring_mem[ring_rd_slot][i];
          db.last = (i + 1 == int'(ring_len[ring_rd_slot]));
          expected_drain_bytes.push_back(db);
        end
        ring_rd_slot = ring_advance(ring_rd_slot);
        ring_held--;
      end
    end
  endtask

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic push_req(input logic kind, input logic [7:0] data, input logic eom);
    ring_req_t req;
    req.kind = kind;
    req.data = data;
    req.eom  = eom;
    req.gap  = no_idle ? 0 : $urandom_range(0, 4);
    request_queue.push_back(req);
    pushed++;
  endtask

  task automatic push_drain();
    push_req(mring_pkg::KindDrain, 8'($urandom), 1'($urandom));
  endtask

  task automatic push_message(input int unsigned len, input bit drain_inside);
    int unsigned cut;
    cut = $urandom_range(0, len - 1);
    for (int unsigned i = 0; i < len; i++) begin
      if (drain_inside && i == cut && i != 0) push_drain();
      push_req(mring_pkg::KindWrite, 8'($urandom), i + 1 == len);
    end
  endtask

  // driver: one request held on the pins until the ring takes it
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start            <= 1'b0;
      kind_i           <= mring_pkg::KindWrite;
      in_byte_i        <= 8'h00;
      end_of_message_i <= 1'b0;
    end else begin
      if (start && !busy) apply_ring_request(cur_req);
      if (!start || !busy) begin
        if (!have_req && request_queue.size() > 0) begin
          cur_req  = request_queue.pop_front();
          have_req = 1'b1;
          gap_left = cur_req.gap;
        end
        if (have_req && gap_left == 0) begin
          start            <= 1'b1;
          kind_i           <= cur_req.kind;
          in_byte_i        <= cur_req.data;
          end_of_message_i <= cur_req.eom;
          have_req = 1'b0;
        end else begin
          start <= 1'b0;
          if (have_req) gap_left--;
        end
      end
    end
  end

  // monitor: every strobed byte must match the oldest expected byte
  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      if (expected_drain_bytes.size() == 0) begin
        flag_mismatch($sformatf("unexpected byte %02h last %0b", out_byte_o, last_of_run_o));
      end else begin
        drain_byte_t exp_b;
        exp_b = expected_drain_bytes.pop_front();
        n_checked++;
        if (out_byte_o !== exp_b.data)
          flag_mismatch($sformatf("out_byte expected %02h got %02h", exp_b.data, out_byte_o));
        if (last_of_run_o !== exp_b.last)
          flag_mismatch($sformatf("last_of_run expected %0b got %0b", exp_b.last,
                                  last_of_run_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d bytes still expected", cycle_count,
               expected_drain_bytes.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int unsigned r;
    int unsigned p;
    int unsigned len;
    int unsigned directed;

    // drain on empty ring, byte extremes, drain during assembly
    push_drain();
    push_req(mring_pkg::KindWrite, 8'h00, 1'b1);
    push_req(mring_pkg::KindWrite, 8'hFF, 1'b0);
    push_req(mring_pkg::KindWrite, 8'hA5, 1'b1);
    push_req(mring_pkg::KindWrite, 8'h5A, 1'b0);
    push_drain();
    push_req(mring_pkg::KindWrite, 8'h3C, 1'b1);
    // fill past capacity so the oldest message is discarded
    for (int i = 0; i < 7; i++) push_req(mring_pkg::KindWrite, 8'(8'h11 * (i + 1)), 1'b1);
    push_drain();
    push_drain();
    directed = pushed;

    while (pushed < directed + RandomRequests) begin
      if ($urandom_range(0, 9) == 0) no_idle = !no_idle;
      r = $urandom_range(0, 99);
      if (r < 50) begin
        p = $urandom_range(0, 99);
        if (p < 84)      len = $urandom_range(1, 6);
        else if (p < 96) len = $urandom_range(7, mring_pkg::BytesPerSlot);
        else             len = $urandom_range(mring_pkg::BytesPerSlot,
                                              mring_pkg::BytesPerSlot + 6);
        push_message(len, $urandom_range(0, 19) == 0);
      end else if (r < 85) begin
        push_drain();
      end else if (r < 95) begin
        len = $urandom_range(2, mring_pkg::Slots + 2);
        for (int unsigned i = 0; i < len; i++) push_message($urandom_range(1, 2), 1'b0);
      end else if (r < 98) begin
        len = $urandom_range(2, 3);
        for (int unsigned i = 0; i < len; i++) push_drain();
      end else begin
        push_req(mring_pkg::KindWrite, 8'($urandom), 1'($urandom));
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_queue.size() != 0 || have_req || start ||
           expected_drain_bytes.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("requests: %0d writes, %0d drains (%0d on an empty ring)", n_writes, n_drains,
             n_empty_drains);
    $display("checked %0d drained bytes; %0d oldest-message discards, %0d bytes past slot end",
             n_checked, n_overwrites, n_dropped_bytes);
    if (mismatches == 0 && expected_drain_bytes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/mring_pkg.sv
hw/rtl/mring_ram.sv
hw/rtl/message_ring_overwrite_oldest_core.sv
bench/message_ring_overwrite_oldest_core_tb.sv
